/* rtl/first_fit_heap_allocator_assert.svh */
// Assertion macros for the heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define FFHA_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define FFHA_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

/* rtl/ffha_pkg.sv */
package ffha_pkg;

    localparam int MAX_BLOCKS_DEF = 64;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_INIT  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO_REQ  = 3'd1;
    localparam logic [2:0] ST_NO_FIT    = 3'd2;
    localparam logic [2:0] ST_NULL_FREE = 3'd3;
    localparam logic [2:0] ST_ALREADY   = 3'd4;
    localparam logic [2:0] ST_INVALID   = 3'd5;

    localparam logic [1:0] REG_HEAP_START = 2'd0;
    localparam logic [1:0] REG_HEAP_SIZE  = 2'd1;
    localparam logic [1:0] REG_HEADER     = 2'd2;
    localparam logic [1:0] REG_MIN_SPLIT  = 2'd3;

    localparam logic [6:0] HEADER_RESET    = 7'd16;
    localparam logic [7:0] MIN_SPLIT_RESET = 8'd16;

    // One table entry: header offset, payload size, free mark.
    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] payload;
        logic        is_free;
    } entry_t;

endpackage

/* rtl/ffha_if.sv */
interface ffha_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] request_bytes;
    logic [31:0] free_address;
    modport source (output valid, op, request_bytes, free_address, input ready);
    modport sink   (input valid, op, request_bytes, free_address, output ready);
endinterface

interface ffha_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] address;
    logic [31:0] used_bytes;
    logic [31:0] total_bytes;
    modport source (output valid, status, address, used_bytes, total_bytes, input ready);
    modport sink   (input valid, status, address, used_bytes, total_bytes, output ready);
endinterface

interface ffha_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/ffha_table.sv */
// Block table memory: one write port, one registered read port.
module ffha_table #(
    parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF,
    localparam int AW = $clog2(MAX_BLOCKS)
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  ffha_pkg::entry_t      wdata,
    input  logic [AW-1:0]         raddr,
    output ffha_pkg::entry_t      rdata
);
    ffha_pkg::entry_t mem [MAX_BLOCKS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/first_fit_heap_allocator.sv */
// Channel | Role   | Word
// in      | sink   | op, request_bytes, free_address
// out     | source | status, address, used_bytes, total_bytes
// cfg     | sink   | index, data (register write)
//
// One item at a time. A scan reads table entries one by one (S_SREAD, S_SCHK;
// the table read is registered); a split or merge then shifts the tail one
// entry at a time (read state, write state). Reset clears count, usage, heap
// start and size, and loads the header and min-split defaults.
// The result waits in its own output register, so in is ready again while
// it is held; a stalled result keeps the next one in S_DONE and cfg not ready.
`include "first_fit_heap_allocator_assert.svh"
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF,
    localparam int AW = $clog2(MAX_BLOCKS),
    localparam int CW = $clog2(MAX_BLOCKS + 1)
) (
    input  logic        clk,
    input  logic        rst_n,
    ffha_in_if.sink     in_ch,
    ffha_out_if.source  out_ch,
    ffha_cfg_if.sink    cfg
);
    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SREAD  = 4'd1;  // issue read of idx
    localparam logic [3:0] S_SCHK   = 4'd3;  // check entry
    localparam logic [3:0] S_GROW   = 4'd4;  // shift up: read k-1
    localparam logic [3:0] S_GROWW  = 4'd5;  // write k
    localparam logic [3:0] S_SPLIT  = 4'd6;  // write free remainder at idx+1
    localparam logic [3:0] S_NEXTR  = 4'd7;  // free: read neighbor
    localparam logic [3:0] S_NEXTC  = 4'd8;
    localparam logic [3:0] S_PREVR  = 4'd9;
    localparam logic [3:0] S_PREVC  = 4'd10;
    localparam logic [3:0] S_SHR    = 4'd11; // shift down: read k+1
    localparam logic [3:0] S_SHW    = 4'd12; // write k
    localparam logic [3:0] S_DONE   = 4'd13;
    localparam logic [3:0] S_SPLIT2 = 4'd14;
    localparam logic [3:0] S_PREVW  = 4'd15;

    logic [3:0]  state_reg, state_next;
    logic [31:0] heap_start_reg, heap_size_reg;
    logic [6:0]  header_reg;
    logic [7:0]  min_split_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0] used_reg, used_next;
    logic [CW-1:0] idx_reg, idx_next;   // current entry
    logic [CW-1:0] k_reg, k_next;       // shift cursor
    logic        rm2_reg, rm2_next;     // a second removal pending (prev merge)
    logic [1:0]  op_reg;
    logic [32:0] need_reg;              // rounded request, no wrap
    logic [31:0] faddr_reg;
    ffha_pkg::entry_t cur_reg, cur_next; // entry at idx
    ffha_pkg::entry_t rdata;
    logic        out_valid_reg;
    logic [2:0]  status_reg, status_next;
    logic [31:0] addr_reg, addr_next;
    // result word held for the out channel
    logic [2:0]  out_status_reg;
    logic [31:0] out_addr_reg, out_used_reg, out_total_reg;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    ffha_pkg::entry_t wdata;

    ffha_table #(.MAX_BLOCKS(MAX_BLOCKS)) u_table (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign cfg.ready   = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_ch.ready = (state_reg == S_IDLE);

    logic [31:0] hdr32, paddr;
    logic [33:0] split_need;
    assign hdr32 = {25'd0, header_reg};
    assign paddr = heap_start_reg + rdata.offset + hdr32;
    assign split_need = {1'b0, need_reg} + {27'd0, header_reg} + {26'd0, min_split_reg};

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        used_next   = used_reg;
        idx_next    = idx_reg;
        k_next      = k_reg;
        rm2_next    = rm2_reg;
        cur_next    = cur_reg;
        status_next = status_reg;
        addr_next   = addr_reg;
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = cur_reg;
        raddr = idx_reg[AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    status_next = ffha_pkg::ST_OK;
                    addr_next   = '0;
                    idx_next    = '0;
                    unique case (in_ch.op)
                        ffha_pkg::OP_ALLOC:
                        begin
                            if (in_ch.request_bytes == '0)
                            begin
                                status_next = ffha_pkg::ST_ZERO_REQ;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SREAD;
                            end
                        end
                        ffha_pkg::OP_FREE:
                        begin
                            if (in_ch.free_address == '0)
                            begin
                                status_next = ffha_pkg::ST_NULL_FREE;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SREAD;
                            end
                        end
                        ffha_pkg::OP_INIT:
                        begin
                            used_next  = '0;
                            count_next = '0;
                            if (heap_size_reg >= hdr32)
                            begin
                                we         = 1'b1;
                                waddr      = '0;
                                wdata      = '{offset: '0,
                                               payload: heap_size_reg - hdr32,
                                               is_free: 1'b1};
                                count_next = CW'(1);
                            end
                            state_next = S_DONE;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_SREAD:
            begin
                if (idx_reg >= count_reg)
                begin
                    status_next = (op_reg == ffha_pkg::OP_ALLOC) ?
                                  ffha_pkg::ST_NO_FIT : ffha_pkg::ST_INVALID;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_SCHK;
                end
            end
            S_SCHK:
            begin
                cur_next = rdata;
                if (op_reg == ffha_pkg::OP_ALLOC)
                begin
                    if (rdata.is_free && {1'b0, rdata.payload} >= need_reg)
                    begin
                        addr_next = paddr;
                        if ({2'b0, rdata.payload} >= split_need &&
                            count_reg < CW'(MAX_BLOCKS))
                        begin
                            k_next     = count_reg;
                            state_next = S_GROW;
                        end
                        else
                        begin
                            we    = 1'b1;
                            wdata = '{offset: rdata.offset, payload: rdata.payload,
                                      is_free: 1'b0};
                            used_next  = used_reg + rdata.payload + hdr32;
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + CW'(1);
                        raddr      = AW'(idx_reg + CW'(1));
                        state_next = S_SREAD;
                    end
                end
                else
                begin
                    if (paddr == faddr_reg)
                    begin
                        if (rdata.is_free)
                        begin
                            status_next = ffha_pkg::ST_ALREADY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cur_next.is_free = 1'b1;
                            used_next  = used_reg - (rdata.payload + hdr32);
                            state_next = S_NEXTR;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + CW'(1);
                        raddr      = AW'(idx_reg + CW'(1));
                        state_next = S_SREAD;
                    end
                end
            end
            // ---- split: shift entries idx+1..count-1 up by one
            S_GROW:
            begin
                if (k_reg > idx_reg + CW'(1))
                begin
                    raddr      = AW'(k_reg - CW'(1));
                    state_next = S_GROWW;
                end
                else
                begin
                    state_next = S_SPLIT;
                end
            end
            S_GROWW:
            begin
                we         = 1'b1;
                waddr      = AW'(k_reg);
                wdata      = rdata;
                k_next     = k_reg - CW'(1);
                state_next = S_GROW;
            end
            S_SPLIT:
            begin
                we    = 1'b1;
                waddr = AW'(idx_reg + CW'(1));
                wdata = '{offset: cur_reg.offset + hdr32 + need_reg[31:0],
                          payload: cur_reg.payload - need_reg[31:0] - hdr32,
                          is_free: 1'b1};
                count_next = count_reg + CW'(1);
                state_next = S_SPLIT2;
            end
            S_SPLIT2:
            begin
                we    = 1'b1;
                wdata = '{offset: cur_reg.offset, payload: need_reg[31:0],
                          is_free: 1'b0};
                used_next  = used_reg + need_reg[31:0] + hdr32;
                state_next = S_DONE;
            end
            // ---- free: merge with next, then previous
            S_NEXTR:
            begin
                raddr    = AW'(idx_reg + CW'(1));
                rm2_next = 1'b0;
                if (idx_reg + CW'(1) < count_reg)
                begin
                    state_next = S_NEXTC;
                end
                else
                begin
                    state_next = S_PREVR;
                end
            end
            S_NEXTC:
            begin
                if (rdata.is_free)
                begin
                    cur_next.payload = cur_reg.payload + hdr32 + rdata.payload;
                    k_next     = idx_reg + CW'(1);
                    state_next = S_SHR;
                end
                else
                begin
                    state_next = S_PREVR;
                end
            end
            S_PREVR:
            begin
                raddr = AW'(idx_reg - CW'(1));
                if (idx_reg != '0)
                begin
                    state_next = S_PREVC;
                end
                else
                begin
                    state_next = S_PREVW;
                end
            end
            S_PREVC:
            begin
                if (rdata.is_free)
                begin
                    we    = 1'b1;
                    waddr = AW'(idx_reg - CW'(1));
                    wdata = '{offset: rdata.offset,
                              payload: rdata.payload + hdr32 + cur_reg.payload,
                              is_free: 1'b1};
                    rm2_next   = 1'b1;
                    k_next     = idx_reg;
                    state_next = S_SHR;
                end
                else
                begin
                    state_next = S_PREVW;
                end
            end
            S_PREVW:
            begin
                we         = 1'b1;
                state_next = S_DONE;
            end
            // ---- remove entry k: shift k+1..count-1 down
            S_SHR:
            begin
                if (k_reg + CW'(1) < count_reg)
                begin
                    raddr      = AW'(k_reg + CW'(1));
                    state_next = S_SHW;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    if (rm2_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // next merged; cur is then merged into prev or written back at idx
                        rm2_next   = 1'b0;
                        state_next = S_PREVR;
                    end
                end
            end
            S_SHW:
            begin
                we         = 1'b1;
                waddr      = AW'(k_reg);
                wdata      = rdata;
                k_next     = k_reg + CW'(1);
                state_next = S_SHR;
            end
            S_DONE:
            begin
                // wait here while the previous result word is still held
                if (!out_valid_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            used_reg       <= '0;
            out_valid_reg  <= 1'b0;
            heap_start_reg <= '0;
            heap_size_reg  <= '0;
            header_reg     <= ffha_pkg::HEADER_RESET;
            min_split_reg  <= ffha_pkg::MIN_SPLIT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            used_reg  <= used_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    ffha_pkg::REG_HEAP_START: heap_start_reg <= cfg.data;
                    ffha_pkg::REG_HEAP_SIZE:  heap_size_reg  <= cfg.data;
                    ffha_pkg::REG_HEADER:     header_reg     <= cfg.data[6:0];
                    ffha_pkg::REG_MIN_SPLIT:  min_split_reg  <= cfg.data[7:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            else if (state_reg == S_DONE && state_next == S_IDLE)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        k_reg      <= k_next;
        rm2_reg    <= rm2_next;
        cur_reg    <= cur_next;
        status_reg <= status_next;
        addr_reg   <= addr_next;
        if (in_ch.valid && in_ch.ready)
        begin
            op_reg    <= in_ch.op;
            need_reg  <= ({1'b0, in_ch.request_bytes} + 33'd7) & ~33'd7;
            faddr_reg <= in_ch.free_address;
        end
        if (state_reg == S_DONE && state_next == S_IDLE)
        begin
            out_status_reg <= status_reg;
            out_addr_reg   <= addr_reg;
            out_used_reg   <= used_reg;
            out_total_reg  <= heap_size_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = out_status_reg;
    assign out_ch.address     = out_addr_reg;
    assign out_ch.used_bytes  = out_used_reg;
    assign out_ch.total_bytes = out_total_reg;

    `FFHA_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_reg <= CW'(MAX_BLOCKS),
        "block count above table depth")
    `FFHA_ASSERT_IMP(a_busy_no_accept, clk, rst_n, state_reg != S_IDLE, !in_ch.ready,
        "input accepted while busy")
    `FFHA_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_ch.valid && in_ch.ready,
        state_reg != S_IDLE, "accepted item did not start")
    `FFHA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready,
        out_ch.valid && $stable(out_ch.used_bytes), "result word dropped while stalled")
endmodule
